@@ hw/rtl/lbf_pkg.sv @@
package lbf_pkg;

   localparam int TABLE_DEPTH_DEF = 64;
   localparam int MAX_PORTS_DEF   = 16;

   localparam int MAC_W      = 48;
   localparam int PORT_W     = 4;
   localparam int MASK_W     = 16;
   localparam int PCOUNT_W   = 5;
   localparam int SCOUNT_W   = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 48;
   localparam int LIMIT_W    = 7;

   // Two entries between the classifier and the table engine
   localparam int QUEUE_DEPTH = 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CFG_PORT_COUNT   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CFG_STATIC_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CFG_STATIC_ADDR_A = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CFG_STATIC_PORT_A = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CFG_STATIC_ADDR_B = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CFG_STATIC_PORT_B = 3'd5;

   // One classified frame header, as handed from front to back
   typedef struct packed {
      logic [PORT_W-1:0] in_port;
      logic [MAC_W-1:0]  src_addr;
      logic [MAC_W-1:0]  dst_addr;
      logic              same_addr;
      logic              src_static;
      logic              dst_static;
      logic [PORT_W-1:0] static_port;
      logic [MASK_W-1:0] flood_mask;
   } lbf_item_type;

endpackage

@@ hw/rtl/lbf_front.sv @@
module lbf_front import lbf_pkg::*; #(
   parameter int MAX_PORTS = MAX_PORTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PORT_W-1:0]     req_in_port,
   input  logic [MAC_W-1:0]      req_src_addr,
   input  logic [MAC_W-1:0]      req_dst_addr,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   input  logic                  q_full,
   output logic                  q_push,
   output lbf_item_type          q_item
);

   logic [PCOUNT_W-1:0] port_count_ff, port_count_in;
   logic [SCOUNT_W-1:0] static_count_ff, static_count_in;
   logic [MAC_W-1:0]    static_addr_a_ff, static_addr_a_in;
   logic [PORT_W-1:0]   static_port_a_ff, static_port_a_in;
   logic [MAC_W-1:0]    static_addr_b_ff, static_addr_b_in;
   logic [PORT_W-1:0]   static_port_b_ff, static_port_b_in;

   logic               a_active;
   logic               b_active;
   logic [LIMIT_W-1:0] port_limit;

   assign csr_ready = 1'b1;

   always_comb begin
      port_count_in    = port_count_ff;
      static_count_in  = static_count_ff;
      static_addr_a_in = static_addr_a_ff;
      static_port_a_in = static_port_a_ff;
      static_addr_b_in = static_addr_b_ff;
      static_port_b_in = static_port_b_ff;
      if (csr_valid) begin
         case (csr_index)
            CFG_PORT_COUNT:    port_count_in    = csr_data[PCOUNT_W-1:0];
            CFG_STATIC_COUNT:  static_count_in  = csr_data[SCOUNT_W-1:0];
            CFG_STATIC_ADDR_A: static_addr_a_in = csr_data[MAC_W-1:0];
            CFG_STATIC_PORT_A: static_port_a_in = csr_data[PORT_W-1:0];
            CFG_STATIC_ADDR_B: static_addr_b_in = csr_data[MAC_W-1:0];
            CFG_STATIC_PORT_B: static_port_b_in = csr_data[PORT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         port_count_ff    <= PCOUNT_W'(16);
         static_count_ff  <= '0;
         static_addr_a_ff <= '0;
         static_port_a_ff <= '0;
         static_addr_b_ff <= '0;
         static_port_b_ff <= '0;
      end else begin
         port_count_ff    <= port_count_in;
         static_count_ff  <= static_count_in;
         static_addr_a_ff <= static_addr_a_in;
         static_port_a_ff <= static_port_a_in;
         static_addr_b_ff <= static_addr_b_in;
         static_port_b_ff <= static_port_b_in;
      end
   end

   // A count of three behaves as two
   assign a_active = (static_count_ff != '0);
   assign b_active = static_count_ff[1];

   assign port_limit = (32'(port_count_ff) > MAX_PORTS) ? LIMIT_W'(MAX_PORTS)
                                                       : LIMIT_W'(port_count_ff);

   always_comb begin
      q_item.in_port    = req_in_port;
      q_item.src_addr   = req_src_addr;
      q_item.dst_addr   = req_dst_addr;
      q_item.same_addr  = (req_src_addr == req_dst_addr);
      q_item.src_static = (a_active && req_src_addr == static_addr_a_ff) ||
                          (b_active && req_src_addr == static_addr_b_ff);
      q_item.dst_static = 1'b0;
      q_item.static_port = '0;
      // Entry a has priority over entry b
      if (a_active && req_dst_addr == static_addr_a_ff) begin
         q_item.dst_static  = 1'b1;
         q_item.static_port = static_port_a_ff;
      end else if (b_active && req_dst_addr == static_addr_b_ff) begin
         q_item.dst_static  = 1'b1;
         q_item.static_port = static_port_b_ff;
      end
      for (int i = 0; i < MASK_W; i++) begin
         q_item.flood_mask[i] = (LIMIT_W'(i) < port_limit) && (PORT_W'(i) != req_in_port);
      end
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

endmodule

@@ hw/rtl/lbf_queue.sv @@
module lbf_queue import lbf_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  lbf_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output lbf_item_type head_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   lbf_item_type     slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(ptr + 1'b1);
   endfunction

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

@@ hw/rtl/lbf_back.sv @@
module lbf_back import lbf_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  lbf_item_type      q_item,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [MASK_W-1:0] rsp_egress_mask,
   output logic              rsp_flooded,
   output logic              rsp_learn_dropped
);

   localparam int IDX_W   = $clog2(TABLE_DEPTH);
   localparam int FILL_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_W = MAC_W + PORT_W;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } lbf_state_type;

   lbf_state_type state_ff, state_in;
   lbf_item_type  item_ff, item_in;

   logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               rd_en;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;

   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [FILL_W-1:0] scan_idx_ff, scan_idx_in;
   logic              rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]  rd_idx_ff, rd_idx_in;
   logic              src_hit_ff, src_hit_in;
   logic [IDX_W-1:0]  src_idx_ff, src_idx_in;
   logic              dst_hit_ff, dst_hit_in;
   logic [PORT_W-1:0] dst_port_ff, dst_port_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] rsp_mask_ff, rsp_mask_in;
   logic              rsp_flooded_ff, rsp_flooded_in;
   logic              rsp_dropped_ff, rsp_dropped_in;

   logic              do_update;
   logic              do_append;
   logic              do_drop;
   logic              table_full;

   assign table_full = (fill_ff == FILL_W'(TABLE_DEPTH));
   assign do_update  = !item_ff.src_static && src_hit_ff;
   assign do_append  = !item_ff.src_static && !src_hit_ff && !table_full;
   assign do_drop    = !item_ff.src_static && !src_hit_ff && table_full;
   assign wr_addr    = do_update ? src_idx_ff : fill_ff[IDX_W-1:0];

   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      fill_in        = fill_ff;
      scan_idx_in    = scan_idx_ff;
      rd_en          = 1'b0;
      rd_vld_in      = 1'b0;
      rd_idx_in      = rd_idx_ff;
      src_hit_in     = src_hit_ff;
      src_idx_in     = src_idx_ff;
      dst_hit_in     = dst_hit_ff;
      dst_port_in    = dst_port_ff;
      wr_en          = 1'b0;
      q_pop          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_mask_in    = rsp_mask_ff;
      rsp_flooded_in = rsp_flooded_ff;
      rsp_dropped_in = rsp_dropped_ff;

      // Compare the entry read last cycle; keep the first match
      if (rd_vld_ff) begin
         if (!src_hit_ff && rd_data_ff[ENTRY_W-1:PORT_W] == item_ff.src_addr) begin
            src_hit_in = 1'b1;
            src_idx_in = rd_idx_ff;
         end
         if (!dst_hit_ff && rd_data_ff[ENTRY_W-1:PORT_W] == item_ff.dst_addr) begin
            dst_hit_in  = 1'b1;
            dst_port_in = rd_data_ff[PORT_W-1:0];
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               item_in     = q_item;
               scan_idx_in = '0;
               src_hit_in  = 1'b0;
               dst_hit_in  = 1'b0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_idx_ff != fill_ff) begin
               rd_en       = 1'b1;
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_idx_ff[IDX_W-1:0];
               scan_idx_in = scan_idx_ff + 1'b1;
            end else if (!rd_vld_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               wr_en          = do_update || do_append;
               fill_in        = do_append ? FILL_W'(fill_ff + 1'b1) : fill_ff;
               rsp_valid_in   = 1'b1;
               rsp_dropped_in = do_drop;
               rsp_flooded_in = 1'b0;
               if (item_ff.dst_static) begin
                  rsp_mask_in = MASK_W'(1) << item_ff.static_port;
               end else if (dst_hit_ff) begin
                  // Destination equal to a learned source sees the fresh port
                  rsp_mask_in = (item_ff.same_addr && !item_ff.src_static)
                              ? MASK_W'(1) << item_ff.in_port
                              : MASK_W'(1) << dst_port_ff;
               end else if (item_ff.same_addr && do_append) begin
                  rsp_mask_in = MASK_W'(1) << item_ff.in_port;
               end else begin
                  rsp_mask_in    = item_ff.flood_mask;
                  rsp_flooded_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff        <= item_in;
      scan_idx_ff    <= scan_idx_in;
      rd_idx_ff      <= rd_idx_in;
      src_hit_ff     <= src_hit_in;
      src_idx_ff     <= src_idx_in;
      dst_hit_ff     <= dst_hit_in;
      dst_port_ff    <= dst_port_in;
      rsp_mask_ff    <= rsp_mask_in;
      rsp_flooded_ff <= rsp_flooded_in;
      rsp_dropped_ff <= rsp_dropped_in;
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= table_mem[scan_idx_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= {item_ff.src_addr, item_ff.in_port};
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_egress_mask   = rsp_mask_ff;
   assign rsp_flooded       = rsp_flooded_ff;
   assign rsp_learn_dropped = rsp_dropped_ff;

`ifndef NO_ASSERTIONS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= TABLE_DEPTH)
      else $error("fill count beyond table depth");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |-> fill_ff == $past(fill_ff) + 1'b1)
      else $error("fill count moved by other than one");

   a_write_in_done: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_DONE && !rd_vld_ff))
      else $error("table written outside completion");

   a_pop_in_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE && q_valid))
      else $error("queue popped while engine busy");
`endif

endmodule

@@ hw/rtl/learning_bridge_forwarder_unit.sv @@
// Learning bridge forwarding unit.
// Request channel (req_valid / req_stall): one frame header per transaction,
// ingress port plus source and destination MAC. Response channel (rsp_valid /
// rsp_stall): one result per header, in order: egress mask, flood flag and a
// flag set when a new source could not be learned because the table is full.
// Config channel (csr_valid / csr_ready, csr_index, csr_data): port count,
// static entry count, and two static address/port pairs; write only while idle.
// The front classifies a header against the static entries in the cycle it is
// accepted and pushes it into a two-entry queue. The back engine scans the
// learned table through a single-port memory, one entry per cycle, then
// learns the source and forms the result. It reads every learned entry of
// the table for each header, and takes the next header from the queue only
// after the result of the last one has been formed.
// Reset clears the configuration (port count 16) and empties the table and the
// queue. While rsp_stall is high the response holds; the engine stops at its
// completion step and the queue fills, after which req_stall rises.
module learning_bridge_forwarder_unit import lbf_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
   parameter int MAX_PORTS   = MAX_PORTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [PORT_W-1:0]     req_in_port,
   input  logic [MAC_W-1:0]      req_src_addr,
   input  logic [MAC_W-1:0]      req_dst_addr,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [MASK_W-1:0]     rsp_egress_mask,
   output logic                  rsp_flooded,
   output logic                  rsp_learn_dropped,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_valid;
   lbf_item_type push_item;
   lbf_item_type head_item;

   lbf_front #(
      .MAX_PORTS (MAX_PORTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_port  (req_in_port),
      .req_src_addr (req_src_addr),
      .req_dst_addr (req_dst_addr),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_item       (push_item)
   );

   lbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   lbf_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_item            (head_item),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_egress_mask   (rsp_egress_mask),
      .rsp_flooded       (rsp_flooded),
      .rsp_learn_dropped (rsp_learn_dropped)
   );

endmodule
